### sv/iwa_pkg.sv
// Shared types, constants and scale tables for the IMU window-average block.
package iwa_pkg;

    localparam int NCH        = 6;
    localparam int NAXIS      = 3;
    localparam int RAW_W      = 16;
    localparam int OUT_W      = 25;
    localparam int BIAS_W     = 24;
    localparam int CNT_W      = 5;
    localparam int RANGE_W    = 2;
    localparam int K_W        = 25;
    localparam int Q_FRAC     = 16;
    localparam int WINDOW_DEF = 16;
    localparam int DIV_BITS   = 4;
    localparam int Q_DEPTH    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BIAS_W;

    localparam int IN_TDATA_W  = ((NCH * RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NCH * OUT_W + CNT_W + 7) / 8) * 8;

    typedef logic [NCH-1:0][RAW_W-1:0] raw_sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_RANGE,
        REG_GYRO_RANGE,
        REG_GYRO_BIAS_X,
        REG_GYRO_BIAS_Y,
        REG_GYRO_BIAS_Z,
        REG_ACCEL_BIAS_X,
        REG_ACCEL_BIAS_Y,
        REG_ACCEL_BIAS_Z
    } reg_idx_t;

    typedef struct packed {
        logic [RANGE_W-1:0]           accel_range;
        logic [RANGE_W-1:0]           gyro_range;
        logic [NCH-1:0][BIAS_W-1:0]   bias;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_SGN,
        ST_OUT
    } back_state_t;

    // Q.16 output per raw count, scaled by a further 65536.
    function automatic logic [K_W-1:0] gyro_k(input logic [RANGE_W-1:0] sel);
        logic [K_W-1:0] k;
        unique case (sel)
            2'd0: k = K_W'(571909);
            2'd1: k = K_W'(1143819);
            2'd2: k = K_W'(2287638);
            2'd3: k = K_W'(4575276);
        endcase
        return k;
    endfunction

    function automatic logic [K_W-1:0] accel_k(input logic [RANGE_W-1:0] sel);
        logic [K_W-1:0] k;
        unique case (sel)
            2'd0: k = K_W'(2570754);
            2'd1: k = K_W'(5141509);
            2'd2: k = K_W'(10283018);
            2'd3: k = K_W'(20566036);
        endcase
        return k;
    endfunction

endpackage

### sv/iwa_front.sv
// Input side: accepts raw samples and holds them in a two-entry queue for the back end.
module iwa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // raw_gx, raw_gy, raw_gz, raw_ax, raw_ay, raw_az from bit 0 up
    input  logic [iwa_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                          q_valid,
    input  logic                          q_ready,
    output iwa_pkg::raw_sample_t          q_data
);
    import iwa_pkg::*;

    raw_sample_t slot_mem [Q_DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign s_tready = (count_reg != 2'(Q_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = slot_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= raw_sample_t'(s_tdata[NCH*RAW_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### sv/iwa_div.sv
// Six-lane restoring divider that retires DIV_BITS quotient bits per cycle.
module iwa_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [iwa_pkg::NCH-1:0][DVD_W-1:0]   dvd,
    input  logic [DVS_W-1:0]                     dvs,
    output logic                                 done,
    output logic [iwa_pkg::NCH-1:0][DVD_W-1:0]   quo
);
    import iwa_pkg::*;

    localparam int CYC   = (DVD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W = CYC * DIV_BITS;
    localparam int CYC_W = (CYC > 1) ? $clog2(CYC) : 1;

    logic [PAD_W-1:0] work_reg  [NCH];
    logic [PAD_W-1:0] work_next [NCH];
    logic [DVS_W-1:0] rem_reg   [NCH];
    logic [DVS_W-1:0] rem_next  [NCH];
    logic [DVS_W-1:0] dvs_reg;
    logic [CYC_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb
    begin
        logic [PAD_W-1:0] w;
        logic [DVS_W-1:0] r;
        logic [DVS_W:0]   sh;
        logic [DVS_W+1:0] trial;
        for (int l = 0; l < NCH; l++)
        begin
            w = work_reg[l];
            r = rem_reg[l];
            for (int s = 0; s < DIV_BITS; s++)
            begin
                sh    = {r, w[PAD_W-1]};
                trial = {1'b0, sh} - {2'b00, dvs_reg};
                if (!trial[DVS_W+1])
                begin
                    r = trial[DVS_W-1:0];
                    w = {w[PAD_W-2:0], 1'b1};
                end
                else
                begin
                    r = sh[DVS_W-1:0];
                    w = {w[PAD_W-2:0], 1'b0};
                end
            end
            work_next[l] = w;
            rem_next[l]  = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= dvs;
            for (int l = 0; l < NCH; l++)
            begin
                work_reg[l] <= PAD_W'(dvd[l]);
                rem_reg[l]  <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < NCH; l++)
            begin
                work_reg[l] <= work_next[l];
                rem_reg[l]  <= rem_next[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CYC_W'(CYC - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CYC_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int l = 0; l < NCH; l++)
        begin
            quo[l] = work_reg[l][DVD_W-1:0];
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");

    a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while busy");

endmodule

### sv/iwa_back.sv
// Processing side: sample ring, running sums, scaling, division, bias and saturation.
module iwa_back #(
    parameter int WINDOW = iwa_pkg::WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  iwa_pkg::raw_sample_t            q_data,
    input  iwa_pkg::cfg_t                   cfg,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [iwa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import iwa_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = RAW_W + $clog2(WINDOW) + 1;
    localparam int PROD_W = SUM_W + K_W + 1;
    localparam int MAG_W  = PROD_W + 1;
    localparam int DVD_W  = MAG_W - Q_FRAC;
    localparam int V_W    = DVD_W + 2;
    localparam logic signed [V_W-1:0] V_MAX = V_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [V_W-1:0] V_MIN = -V_MAX - V_W'(1);
    localparam int PAD_W  = OUT_TDATA_W - NCH * OUT_W - CNT_W;

    back_state_t state_reg, state_next;

    raw_sample_t ring_mem [WINDOW];
    raw_sample_t old_reg;
    raw_sample_t cur_reg;

    logic [SLOT_W-1:0]        slot_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic                     full;
    logic signed [SUM_W-1:0]  sum_reg  [NCH];
    logic signed [PROD_W-1:0] prod_reg [NCH];
    logic signed [PROD_W-1:0] prod_next [NCH];
    logic [NCH-1:0]           neg_reg;
    logic signed [DVD_W:0]    sq_reg   [NCH];
    logic signed [DVD_W:0]    sq_next  [NCH];

    logic [NCH-1:0][DVD_W-1:0] dvd;
    logic [NCH-1:0][DVD_W-1:0] quo;
    logic                      div_start;
    logic                      div_done;

    logic [NCH-1:0][OUT_W-1:0] out_ch_reg;
    logic [NCH-1:0][OUT_W-1:0] out_ch_next;
    logic [CNT_W-1:0]          out_cnt_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_load;

    assign full = (fill_reg == FILL_W'(WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: state_next = ST_MUL;
            ST_MUL: state_next = ST_ABS;
            ST_ABS:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SGN;
                end
            end
            ST_SGN: state_next = ST_OUT;
            ST_OUT:
            begin
                // The finished result waits here only while the previous one is unread.
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Ring read is registered; on the accepting edge it returns the entry being replaced.
    always_ff @(posedge clk)
    begin
        old_reg <= ring_mem[slot_reg];
        if (state_reg == ST_IDLE && q_valid)
        begin
            ring_mem[slot_reg] <= q_data;
            cur_reg            <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            for (int k = 0; k < NCH; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else if (state_reg == ST_SUM)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                sum_reg[k] <= sum_reg[k]
                    - (full ? SUM_W'($signed(old_reg[k])) : SUM_W'(0))
                    + SUM_W'($signed(cur_reg[k]));
            end
            slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
            if (!full)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    always_comb
    begin
        logic [K_W-1:0]          kk;
        logic signed [MAG_W-1:0] p_ext;
        logic [MAG_W-1:0]        rnd;
        logic [MAG_W-1:0]        mag;
        for (int k = 0; k < NCH; k++)
        begin
            kk           = (k < NAXIS) ? gyro_k(cfg.gyro_range) : accel_k(cfg.accel_range);
            prod_next[k] = sum_reg[k] * $signed({1'b0, kk});
            // Adding n/2 in the output scale rounds half away from zero.
            p_ext  = {prod_reg[k][PROD_W-1], prod_reg[k]};
            rnd    = MAG_W'({fill_reg, 15'b0});
            mag    = prod_reg[k][PROD_W-1] ? (rnd - p_ext) : (p_ext + rnd);
            dvd[k] = mag[MAG_W-1:Q_FRAC];
            sq_next[k] = neg_reg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
        end
    end

    always_comb
    begin
        logic signed [V_W-1:0] v;
        logic signed [V_W-1:0] b_ext;
        for (int k = 0; k < NCH; k++)
        begin
            b_ext = {{(V_W - BIAS_W){cfg.bias[k][BIAS_W-1]}}, cfg.bias[k]};
            v     = {sq_reg[k][DVD_W], sq_reg[k]} - b_ext;
            if (v > V_MAX)
            begin
                out_ch_next[k] = V_MAX[OUT_W-1:0];
            end
            else if (v < V_MIN)
            begin
                out_ch_next[k] = V_MIN[OUT_W-1:0];
            end
            else
            begin
                out_ch_next[k] = v[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (state_reg == ST_ABS)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                neg_reg[k] <= prod_reg[k][PROD_W-1];
            end
        end
        if (state_reg == ST_SGN)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
        if (out_load)
        begin
            out_ch_reg  <= out_ch_next;
            out_cnt_reg <= CNT_W'(fill_reg);
        end
    end

    iwa_div #(
        .DVD_W (DVD_W),
        .DVS_W (FILL_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (dvd),
        .dvs   (fill_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_cnt_reg, out_ch_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count beyond window");

    a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && q_valid |=> state_reg == ST_SUM)
        else $error("accepted item not summed next");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> fill_reg != '0)
        else $error("division started with empty window");

endmodule

### sv/imu_window_average_bias_correct.sv
// Top level of the six-channel IMU window average with scaling and bias correction.
// Each item is one six-axis raw sample; each item gives exactly one result: the boxcar
// average over the samples held so far (up to WINDOW), scaled to Q.16 rad/s or m/s^2
// from the range registers, minus the bias registers, saturated to 25 bits, together
// with the number of samples averaged. The divider works on a dividend DVD bits wide (32
// bits at WINDOW 16) in six lanes and retires four quotient bits a cycle. Items are worked
// one at a time, while a two-entry input queue and the output register let both sides
// stall independently. The sample ring needs no clearing after reset; old entries are
// only subtracted once the window is full.
module imu_window_average_bias_correct #(
    parameter int WINDOW = iwa_pkg::WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // raw_gx, raw_gy, raw_gz, raw_ax, raw_ay, raw_az from bit 0 up
    input  logic [iwa_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, samples_averaged from bit 0 up
    output logic [iwa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [iwa_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [iwa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import iwa_pkg::*;

    cfg_t        cfg_reg;
    logic        q_valid;
    logic        q_ready;
    raw_sample_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_ACCEL_RANGE:  cfg_reg.accel_range <= cfg_wdata[RANGE_W-1:0];
                REG_GYRO_RANGE:   cfg_reg.gyro_range  <= cfg_wdata[RANGE_W-1:0];
                REG_GYRO_BIAS_X:  cfg_reg.bias[0]     <= cfg_wdata;
                REG_GYRO_BIAS_Y:  cfg_reg.bias[1]     <= cfg_wdata;
                REG_GYRO_BIAS_Z:  cfg_reg.bias[2]     <= cfg_wdata;
                REG_ACCEL_BIAS_X: cfg_reg.bias[3]     <= cfg_wdata;
                REG_ACCEL_BIAS_Y: cfg_reg.bias[4]     <= cfg_wdata;
                REG_ACCEL_BIAS_Z: cfg_reg.bias[5]     <= cfg_wdata;
            endcase
        end
    end

    iwa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    iwa_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
